// ----- design/sed_pkg.sv -----
`timescale 1ns / 1ps

package sed_pkg;

    // Fraction bits of a probability, 2^FRAC_BITS is 1.0
    localparam int FRAC_BITS = 30;
    // Field widths of the item and result channels
    localparam int DIST_W    = 17;
    localparam int SIZE_W    = 9;
    localparam int PROB_W    = FRAC_BITS + 1;
    // Fraction bits of the distance field
    localparam int DIST_FRAC = 16;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_THR_A,
        ST_THR_B,
        ST_THR_C,
        ST_SWEEP,
        ST_DRAIN_A,
        ST_DRAIN_B,
        ST_DIV,
        ST_FINISH
    } sed_state_t;

    // Controller to datapath
    typedef struct packed {
        logic load;      // latch item, clear row/column state
        logic thr_a;     // distance * m
        logic thr_b;     // * n
        logic thr_c;     // threshold from product
        logic row_next;  // advance row, set up weight division
        logic div_step;  // one quotient bit
        logic issue;     // launch one lattice cell
        logic res_load;  // move final cell to result register
    } sed_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic col_last;  // current column is n
        logic row_last;  // current row is m
        logic div_last;  // last quotient bit this cycle
        logic res_full;  // result register still holds a result
    } sed_stat_t;

endpackage

// ----- design/sed_in_if.sv -----
`timescale 1ns / 1ps

interface sed_in_if;
    import sed_pkg::*;

    logic              valid;
    logic              ready;
    logic [DIST_W-1:0] distance;
    logic [SIZE_W-1:0] size_a;
    logic [SIZE_W-1:0] size_b;

    modport source (output valid, output distance, output size_a, output size_b,
                    input ready);
    modport sink   (input valid, input distance, input size_a, input size_b,
                    output ready);
endinterface

// ----- design/sed_out_if.sv -----
`timescale 1ns / 1ps

interface sed_out_if;
    import sed_pkg::*;

    logic              valid;
    logic              ready;
    logic [PROB_W-1:0] probability;

    modport source (output valid, output probability, input ready);
    modport sink   (input valid, input probability, output ready);
endinterface

// ----- design/sed_ctrl.sv -----
`timescale 1ns / 1ps

module sed_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  sed_pkg::sed_stat_t  stat,
    output sed_pkg::sed_cmd_t   cmd
);
    import sed_pkg::*;

    sed_state_t state_reg;
    sed_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_THR_A;
                end
            end
            ST_THR_A:
            begin
                cmd.thr_a  = 1'b1;
                state_next = ST_THR_B;
            end
            ST_THR_B:
            begin
                cmd.thr_b  = 1'b1;
                state_next = ST_THR_C;
            end
            ST_THR_C:
            begin
                cmd.thr_c  = 1'b1;
                state_next = ST_SWEEP;
            end
            ST_SWEEP:
            begin
                cmd.issue = 1'b1;
                if (stat.col_last)
                begin
                    state_next = ST_DRAIN_A;
                end
            end
            ST_DRAIN_A:
            begin
                state_next = ST_DRAIN_B;
            end
            ST_DRAIN_B:
            begin
                if (stat.row_last)
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    cmd.row_next = 1'b1;
                    state_next   = ST_DIV;
                end
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (stat.div_last)
                begin
                    state_next = ST_SWEEP;
                end
            end
            ST_FINISH:
            begin
                if (!stat.res_full)
                begin
                    cmd.res_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

`ifndef ASSERT_OFF
    // never overwrite a result the receiver has not taken
    a_res_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.res_load |-> !stat.res_full)
        else $error("result loaded while output register full");
`endif

endmodule

// ----- design/sed_dpath.sv -----
`timescale 1ns / 1ps

module sed_dpath #(
    parameter int MAX_SIZE  = 256
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  sed_pkg::sed_cmd_t           cmd,
    output sed_pkg::sed_stat_t          stat,
    input  logic [sed_pkg::DIST_W-1:0]  distance,
    input  logic [sed_pkg::SIZE_W-1:0]  size_a,
    input  logic [sed_pkg::SIZE_W-1:0]  size_b,
    input  logic                        out_ready,
    output logic                        out_valid,
    output logic [sed_pkg::PROB_W-1:0]  probability
);
    import sed_pkg::*;

    localparam int SW    = $clog2(MAX_SIZE + 1);        // size / index width
    localparam int CW    = (SW > SIZE_W) ? SW : SIZE_W;  // clamp compare width
    localparam int DEPTH = MAX_SIZE + 1;
    localparam int VW    = FRAC_BITS + 1;                // cell value, <= 1.0
    localparam int MW    = 2 * FRAC_BITS + 1;            // full product
    localparam int P1W   = DIST_W + SW;
    localparam int PW    = DIST_W + 2 * SW;
    localparam int XW    = 2 * SW;                       // i*n and j*m
    localparam int TW    = PW - DIST_FRAC;               // threshold
    localparam int RW    = SW + 2;                       // divider remainder
    localparam int KW    = $clog2(FRAC_BITS);

    localparam logic [VW-1:0] ONE = VW'(1) << FRAC_BITS;

    // row store
    logic [VW-1:0] mem [DEPTH];

    // item and threshold
    logic [DIST_W-1:0] d_reg;
    logic [SW-1:0]     m_reg, n_reg;
    logic [P1W-1:0]    p1_reg;
    logic [PW-1:0]     p_reg;
    logic [TW-1:0]     t_reg;
    logic              tneg_reg;

    // counters and lattice positions
    logic [SW-1:0]     i_reg, j_reg;
    logic [KW-1:0]     k_reg;
    logic [XW-1:0]     ipos_reg, jpos_reg;

    // divider
    logic [RW-1:0]        r_reg, den_reg;
    logic [FRAC_BITS-1:0] q_reg;

    // cell pipeline
    logic          v1_reg, v2_reg;
    logic [VW-1:0] rd_reg, prod_reg, prev_reg;
    logic          zc1_reg, zc2_reg, first1_reg, first2_reg, row01_reg, row02_reg;
    logic [SW-1:0] addr1_reg, addr2_reg;

    // result
    logic              out_valid_reg;
    logic [PROB_W-1:0] res_reg;

    // combinational
    logic [CW-1:0]     a_ext, b_ext;
    logic [SW-1:0]     a_cl, b_cl;
    logic [SW-1:0]     i_inc;
    logic [XW-1:0]     jpos_cur, diff;
    logic              zc;
    logic [RW-1:0]     r_sh;
    logic [MW-1:0]     mul_full;
    logic [VW-1:0]     cell_val;

    // size clamp: zero -> 1, above MAX_SIZE -> MAX_SIZE
    always_comb
    begin
        a_ext = CW'(size_a);
        b_ext = CW'(size_b);
        if (a_ext == '0)
            a_cl = SW'(1);
        else if (a_ext > CW'(MAX_SIZE))
            a_cl = SW'(MAX_SIZE);
        else
            a_cl = SW'(a_ext);
        if (b_ext == '0)
            b_cl = SW'(1);
        else if (b_ext > CW'(MAX_SIZE))
            b_cl = SW'(MAX_SIZE);
        else
            b_cl = SW'(b_ext);
    end

    assign i_inc = i_reg + SW'(1);

    // |i*n - j*m| > t test
    always_comb
    begin
        jpos_cur = (j_reg == '0) ? '0 : jpos_reg;
        if (ipos_reg >= jpos_cur)
            diff = ipos_reg - jpos_cur;
        else
            diff = jpos_cur - ipos_reg;
        zc = tneg_reg || (TW'(diff) > t_reg);
    end

    assign r_sh     = {r_reg[RW-2:0], 1'b0};
    assign mul_full = MW'(q_reg) * MW'(rd_reg);

    always_comb
    begin
        if (zc2_reg)
            cell_val = '0;
        else if (row02_reg)
            cell_val = ONE;
        else
            cell_val = prod_reg + (first2_reg ? '0 : prev_reg);
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            d_reg <= distance;
            m_reg <= (a_cl > b_cl) ? b_cl : a_cl;
            n_reg <= (a_cl > b_cl) ? a_cl : b_cl;
        end
        if (cmd.thr_a)
            p1_reg <= P1W'(d_reg) * P1W'(m_reg);
        if (cmd.thr_b)
            p_reg <= PW'(p1_reg) * PW'(n_reg);
        if (cmd.thr_c)
        begin
            tneg_reg <= (p_reg == '0);
            t_reg    <= TW'((p_reg - PW'(1)) >> DIST_FRAC);
        end
        if (cmd.load)
            ipos_reg <= '0;
        else if (cmd.row_next)
            ipos_reg <= ipos_reg + XW'(n_reg);
        if (cmd.issue)
            jpos_reg <= jpos_cur + XW'(m_reg);
        if (cmd.row_next)
        begin
            r_reg   <= RW'(i_inc);
            den_reg <= RW'(i_inc) + RW'(n_reg);
            q_reg   <= '0;
        end
        else if (cmd.div_step)
        begin
            if (r_sh >= den_reg)
            begin
                r_reg <= r_sh - den_reg;
                q_reg <= {q_reg[FRAC_BITS-2:0], 1'b1};
            end
            else
            begin
                r_reg <= r_sh;
                q_reg <= {q_reg[FRAC_BITS-2:0], 1'b0};
            end
        end
        // stage 0: read and zero test
        if (cmd.issue)
            rd_reg <= mem[j_reg];
        zc1_reg    <= zc;
        first1_reg <= (j_reg == '0);
        row01_reg  <= (i_reg == '0);
        addr1_reg  <= j_reg;
        // stage 1: weight product
        prod_reg   <= mul_full[2*FRAC_BITS:FRAC_BITS];
        zc2_reg    <= zc1_reg;
        first2_reg <= first1_reg;
        row02_reg  <= row01_reg;
        addr2_reg  <= addr1_reg;
        // stage 2: add left neighbor, write back
        if (v2_reg)
        begin
            mem[addr2_reg] <= cell_val;
            prev_reg       <= cell_val;
        end
        if (cmd.res_load)
            res_reg <= PROB_W'(prev_reg);
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            i_reg         <= '0;
            j_reg         <= '0;
            k_reg         <= '0;
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.load)
            begin
                i_reg <= '0;
                j_reg <= '0;
            end
            else if (cmd.row_next)
            begin
                i_reg <= i_inc;
                j_reg <= '0;
                k_reg <= '0;
            end
            else
            begin
                if (cmd.issue)
                    j_reg <= j_reg + SW'(1);
                if (cmd.div_step)
                    k_reg <= k_reg + KW'(1);
            end
            v1_reg <= cmd.issue;
            v2_reg <= v1_reg;
            if (cmd.res_load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    assign stat.col_last = (j_reg == n_reg);
    assign stat.row_last = (i_reg == m_reg);
    assign stat.div_last = (k_reg == KW'(FRAC_BITS - 1));
    assign stat.res_full = out_valid_reg;

    assign out_valid   = out_valid_reg;
    assign probability = res_reg;

`ifndef ASSERT_OFF
    // write-back never collides with the read of the cell being launched
    a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
        (v2_reg && cmd.issue) |-> (addr2_reg != j_reg))
        else $error("row store read and write at same address");

    // a row is fully written back before the next weight is formed
    a_drained: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_step |-> (!v1_reg && !v2_reg))
        else $error("divider running with cells in flight");

    // a result only appears after the controller loads it
    a_res_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(cmd.res_load))
        else $error("result valid without load");
`endif

endmodule

// ----- design/smirnov_exact_distribution_unit.sv -----
`timescale 1ns / 1ps

// Exact two-sample Smirnov distribution.
// item channel (sink): distance (Q1.16), size_a, size_b. A transfer starts one
//   computation; ready is high only while the unit is idle.
// result channel (source): probability, unsigned Q1.30 (2^30 is 1.0), one
//   transfer per item.
// Sizes are clamped to 1..MAX_SIZE and ordered so m <= n. The lattice is swept
//   one cell per cycle through a three-stage read / multiply / add pipeline
//   over a single-port-write row store of MAX_SIZE+1 entries; each row after
//   the first forms its weight i/(i+n) in a restoring divider, one bit per cycle.
// ready returns the cycle after the result is loaded into the output register,
//   so items are taken one at a time.
// The result sits in an output register, so the next item can run while the
//   receiver stalls; a finished item waits only if the previous result has
//   still not been taken.
// Reset clears the controller and the valid flags; the row store needs no
//   clearing since every entry is written before it is read.
module smirnov_exact_distribution_unit #(
    parameter int MAX_SIZE  = 256
) (
    input  logic        clk,
    input  logic        rst_n,
    sed_in_if.sink      item,
    sed_out_if.source   result
);
    import sed_pkg::*;

    sed_cmd_t  cmd;
    sed_stat_t stat;

    sed_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (item.valid),
        .in_ready (item.ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    sed_dpath #(
        .MAX_SIZE  (MAX_SIZE)
    ) u_dpath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .distance    (item.distance),
        .size_a      (item.size_a),
        .size_b      (item.size_b),
        .out_ready   (result.ready),
        .out_valid   (result.valid),
        .probability (result.probability)
    );

endmodule

// ----- dv/tb_smirnov_exact_distribution_unit.sv -----
`timescale 1ns / 1ps

// Checks the exact two-sample Smirnov unit against a lattice predictor.
// A short table of queries runs first; random queries follow. The sender
// works in bursts. The receiver stalls on a rotating pattern, and once holds
// off for a long stretch.
module tb_smirnov_exact_distribution_unit;
    import sed_pkg::*;

    localparam int     MAX_SIZE       = 256;
    localparam int     CLK_PERIOD     = 12;
    localparam int     RESET_CYCLES   = 7;
    localparam int     RANDOM_QUERIES = 100;
    // Receiver hold-off; queries keep coming so the unit backs up. Long
    // enough for two of the slowest random queries to finish.
    localparam int     HOLD_CYCLES    = 8000;
    localparam int     HOLD_AFTER     = 25;
    // Idle window after the last result, in which a stray extra transfer
    // would show up.
    localparam int     DRAIN_CYCLES   = 500;
    // Timeout with margin over the slowest legal run (one 256x256 lattice, the
    // table, and every random query at its largest).
    localparam longint TIMEOUT_CYCLES = 3_000_000;

    localparam logic [PROB_W-1:0] PROB_ONE = PROB_W'(1) << FRAC_BITS;

    // One row of the directed table. Where check_lit is set, lit_prob is the
    // expected result. Otherwise the predictor supplies it.
    typedef struct packed {
        logic              check_lit;
        logic [PROB_W-1:0] lit_prob;
        logic [DIST_W-1:0] distance;
        logic [SIZE_W-1:0] size_a;
        logic [SIZE_W-1:0] size_b;
    } query_row_t;

    localparam int N_DIRECTED = 18;

    query_row_t directed_rows [N_DIRECTED] = '{
        // Zero distance gives a threshold of -1, so every cell is zero.
        '{1'b1, 31'd0,    17'd0,      9'd1,   9'd1},
        // Zero size is taken as one. An oversize size saturates to MAX_SIZE.
        '{1'b1, 31'd0,    17'd0,      9'd0,   9'd511},
        // Above one, 1x1: the whole lattice is open and the sum is exactly 1.0.
        '{1'b1, PROB_ONE, 17'd65537,  9'd1,   9'd1},
        '{1'b1, PROB_ONE, 17'h1FFFF,  9'd0,   9'd0},
        // Exactly one, 1x1: the corner cells are still cut off.
        '{1'b0, 31'd0,    17'd65536,  9'd1,   9'd1},
        '{1'b0, 31'd0,    17'h1FFFF,  9'd511, 9'd0},
        // Swapped order, then the same pair already ordered.
        '{1'b0, 31'd0,    17'd32768,  9'd20,  9'd7},
        '{1'b0, 31'd0,    17'd16384,  9'd7,   9'd20},
        // Smallest nonzero distance: only the diagonal stays open.
        '{1'b0, 31'd0,    17'd1,      9'd10,  9'd10},
        '{1'b0, 31'd0,    17'd65535,  9'd3,   9'd5},
        '{1'b0, 31'd0,    17'd65536,  9'd4,   9'd4},
        '{1'b0, 31'd0,    17'h05555,  9'd255, 9'd2},
        '{1'b0, 31'd0,    17'h0AAAA,  9'h1AA, 9'h055},
        '{1'b0, 31'd0,    17'h15555,  9'h155, 9'd3},
        '{1'b0, 31'd0,    17'd2048,   9'd64,  9'd64},
        // Full lattice, once.
        '{1'b0, 31'd0,    17'd12288,  9'd256, 9'd256},
        '{1'b0, 31'd0,    17'd40000,  9'd256, 9'd1},
        '{1'b0, 31'd0,    17'd52429,  9'd9,   9'd9}
    };

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    sed_in_if  item_if ();
    sed_out_if result_if ();

    smirnov_exact_distribution_unit #(
        .MAX_SIZE  (MAX_SIZE)
    ) u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_if),
        .result (result_if)
    );

    // Probabilities owed by the unit, oldest first.
    logic [PROB_W-1:0] prob_due_q [$];
    logic [PROB_W-1:0] prob_want;

    int n_sent      = 0;
    int n_random    = 0;
    int n_results   = 0;
    int n_errors    = 0;
    int burst_left  = 0;
    bit hold_done   = 1'b0;

    always
    begin
        clk = 1'b1;
        #(CLK_PERIOD / 2);
        clk = 1'b0;
        #(CLK_PERIOD / 2);
    end

    initial
    begin
        #(TIMEOUT_CYCLES * CLK_PERIOD);
        $display("tb_smirnov_exact_distribution_unit: FAIL");
        $finish;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    function automatic longint effective_size(logic [SIZE_W-1:0] s);
        if (s == 0)
            return 1;
        else if (s > MAX_SIZE)
            return MAX_SIZE;
        else
            return longint'(s);
    endfunction

    // P(D <= x) over the (m+1) x (n+1) lattice. One row is held and updated
    // in place, left to right. Cell (i,j) is open when |i*n - j*m| <= t.
    function automatic logic [PROB_W-1:0] smirnov_cdf(logic [DIST_W-1:0] query_dist,
                                                      logic [SIZE_W-1:0] sa,
                                                      logic [SIZE_W-1:0] sb);
        logic [63:0] cells [0:MAX_SIZE];
        logic [63:0] prod;
        logic [63:0] num;
        logic [63:0] weight;
        longint      m;
        longint      n;
        longint      swap_tmp;
        longint      thr;
        longint      i;
        longint      j;
        longint      gap;
        m = effective_size(sa);
        n = effective_size(sb);
        if (m > n)
        begin
            swap_tmp = m;
            m = n;
            n = swap_tmp;
        end
        // x*m*n - 2^-16, floored. The guard is one LSB of Q1.16.
        prod = 64'(query_dist);
        prod = prod * m * n;
        thr = (prod == 0) ? -1 : longint'((prod - 1) >> DIST_FRAC);
        for (j = 0; j <= n; j++)
            cells[j] = (j * m > thr) ? 64'd0 : 64'(PROB_ONE);
        for (i = 1; i <= m; i++)
        begin
            num = i;
            num = num << FRAC_BITS;
            weight = num / (i + n);
            cells[0] = (i * n > thr) ? 64'd0 : (weight * cells[0]) >> FRAC_BITS;
            for (j = 1; j <= n; j++)
            begin
                gap = i * n - j * m;
                if (gap < 0)
                    gap = -gap;
                cells[j] = (gap > thr) ? 64'd0
                         : ((weight * cells[j]) >> FRAC_BITS) + cells[j - 1];
            end
        end
        return cells[n][PROB_W-1:0];
    endfunction

    // ------------------------------------------------------------------
    // Sender
    // ------------------------------------------------------------------

    // Offer one query, hold it until the transfer, then log what it owes.
    // Called at a rising edge. valid is written once in this step.
    task automatic offer_query(logic [DIST_W-1:0] query_dist, logic [SIZE_W-1:0] sa,
                               logic [SIZE_W-1:0] sb, logic check_lit,
                               logic [PROB_W-1:0] lit_prob);
        item_if.valid    <= 1'b1;
        item_if.distance <= query_dist;
        item_if.size_a   <= sa;
        item_if.size_b   <= sb;
        @(posedge clk);
        while (!item_if.ready)
            @(posedge clk);
        prob_due_q.push_back(check_lit ? lit_prob : smirnov_cdf(query_dist, sa, sb));
        n_sent++;
    endtask

    // Bursts of back-to-back queries, separated by random gaps. Some
    // gaps are zero, so there are long runs with valid held high.
    task automatic pace_sender();
        int gap;
        if (burst_left > 0)
            burst_left--;
        else
        begin
            burst_left = $urandom_range(0, 7);
            gap = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 30);
            if (gap > 0)
            begin
                item_if.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    initial
    begin
        int                k;
        int                pick;
        logic [DIST_W-1:0] query_dist;
        logic [SIZE_W-1:0] sa;
        logic [SIZE_W-1:0] sb;
        logic [SIZE_W-1:0] big;
        logic [SIZE_W-1:0] tiny;

        item_if.valid    <= 1'b0;
        item_if.distance <= '0;
        item_if.size_a   <= '0;
        item_if.size_b   <= '0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table
        for (k = 0; k < N_DIRECTED; k++)
        begin
            offer_query(directed_rows[k].distance, directed_rows[k].size_a,
                        directed_rows[k].size_b, directed_rows[k].check_lit,
                        directed_rows[k].lit_prob);
            pace_sender();
        end

        // Random queries. Most are small lattices so the run stays short.
        // Some are one oversize side against a tiny one, which covers
        // bit 8 of both size fields. A few are mid-size.
        for (k = 0; k < RANDOM_QUERIES; k++)
        begin
            pick = $urandom_range(0, 99);
            query_dist = ($urandom_range(0, 6) == 0) ? DIST_W'($urandom_range(0, 131071))
                                                     : DIST_W'($urandom_range(0, 65535));
            if (pick < 60)
            begin
                sa = SIZE_W'($urandom_range(0, 12));
                sb = SIZE_W'($urandom_range(0, 12));
            end
            else if (pick < 75)
            begin
                big  = SIZE_W'($urandom_range(0, 511));
                tiny = SIZE_W'($urandom_range(0, 6));
                if ($urandom_range(0, 1) == 0)
                begin
                    sa = big;
                    sb = tiny;
                end
                else
                begin
                    sa = tiny;
                    sb = big;
                end
            end
            else if (pick < 90)
            begin
                sa = SIZE_W'($urandom_range(13, 40));
                sb = SIZE_W'($urandom_range(13, 40));
            end
            else
            begin
                // Distances on the edges: zero, exactly one, just above, max.
                sa = SIZE_W'($urandom_range(0, 8));
                sb = SIZE_W'($urandom_range(0, 8));
                case ($urandom_range(0, 3))
                    0:       query_dist = 17'd0;
                    1:       query_dist = 17'd65536;
                    2:       query_dist = 17'd65537;
                    default: query_dist = 17'h1FFFF;
                endcase
            end
            offer_query(query_dist, sa, sb, 1'b0, '0);
            n_random++;
            pace_sender();
        end
        item_if.valid <= 1'b0;

        while (prob_due_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("run: %0d queries (%0d table, %0d random), %0d results checked",
                 n_sent, N_DIRECTED, n_random, n_results);
        $display("run: sizes 0..511 incl. one 256x256 lattice, one %0d-cycle hold-off",
                 HOLD_CYCLES);
        if (n_errors == 0)
            $display("tb_smirnov_exact_distribution_unit: PASS");
        else
            $display("tb_smirnov_exact_distribution_unit: FAIL");
        $finish;
    end

    // ------------------------------------------------------------------
    // Receiver
    // ------------------------------------------------------------------

    // ready rotates through four modes, picked by bits 9:8 of a cycle counter:
    // always ready, coin flip, ready when the counter is a multiple of five,
    // and mostly ready. One long hold-off comes after HOLD_AFTER results. The
    // unit finishes the next query and waits, with item ready low and valid up.
    initial
    begin
        int cyc;
        int held;
        cyc = 0;
        result_if.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            cyc++;
            if (!hold_done && n_results >= HOLD_AFTER)
            begin
                hold_done = 1'b1;
                result_if.ready <= 1'b0;
                for (held = 0; held < HOLD_CYCLES; held++)
                    @(posedge clk);
            end
            else
            begin
                case (cyc[9:8])
                    2'd0:    result_if.ready <= 1'b1;
                    2'd1:    result_if.ready <= 1'($urandom_range(0, 1));
                    2'd2:    result_if.ready <= (cyc % 5 == 0);
                    default: result_if.ready <= ($urandom_range(0, 7) != 0);
                endcase
            end
        end
    end

    // Result check, against the oldest outstanding probability.
    always @(posedge clk)
    begin
        if (rst_n && result_if.valid && result_if.ready)
        begin
            n_results++;
            if (prob_due_q.size() == 0)
            begin
                n_errors++;
                $display("%0t: result with none outstanding: expected none, actual 0x%08h",
                         $time, result_if.probability);
            end
            else
            begin
                prob_want = prob_due_q.pop_front();
                if (result_if.probability !== prob_want)
                begin
                    n_errors++;
                    $display("%0t: probability mismatch: expected 0x%08h, actual 0x%08h",
                             $time, prob_want, result_if.probability);
                end
            end
        end
    end

endmodule
